>>> hdl/c2s_pkg.sv
// ----------------------------------------------------------------------------
// c2s_pkg
// Shared widths, the side-band record and the CORDIC constants for the
// Cartesian to spherical converter.
// ----------------------------------------------------------------------------
package c2s_pkg;

	localparam int COORD_BITS    = 24;
	localparam int ANGLE_BITS    = 32;
	localparam int CORDIC_STAGES = 28;
	localparam int WORK_SHIFT    = 60 - COORD_BITS;
	localparam int WORK_BITS     = 64;
	localparam int ACC_BITS      = ANGLE_BITS + 1;
	localparam int LEN_BITS      = 24;
	localparam int OUT_ANG_BITS  = 32;

	localparam logic [63:0] INV_PI_Q64 = 64'h517CC1B727220A95;

	localparam logic signed [ACC_BITS-1:0] QUARTER = ACC_BITS'(64'd1 << (ANGLE_BITS - 2));
	localparam logic signed [ACC_BITS:0]   HALF_M1 = (ACC_BITS + 1)'((64'd1 << (ANGLE_BITS - 1)) - 64'd1);

	typedef logic signed [WORK_BITS-1:0] work_t;
	typedef logic signed [ACC_BITS-1:0]  acc_t;

	// what travels alongside a request through the chains and multipliers
	typedef struct packed {
		work_t z;
		acc_t  az;
		acc_t  lat;
		logic  skip;
	} side_t;

	// restoring division, elaboration only
	function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
		logic [64:0] r;
		logic [63:0] q;
		r = '0;
		q = '0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[63:0], n[b]};
			if (r >= {1'b0, d}) begin
				r = r - {1'b0, d};
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// round(atan(2^-i)/pi * 2^(ANGLE_BITS-1))
	function automatic logic [63:0] atan_entry(input int i);
		logic signed [63:0] acc;
		logic [63:0]  term;
		logic [63:0]  hq;
		logic [127:0] prod;
		int           e;
		acc = '0;
		if (i == 0) begin
			hq = 64'd1 << 60;
		end else begin
			for (int k = 0; k < 64; k++) begin
				e = 62 - i * (2 * k + 1);
				if (e >= 0) begin
					term = udiv64(64'd1 << e, 64'(2 * k + 1));
					if (k % 2 == 1) begin
						acc = acc - $signed(term);
					end else begin
						acc = acc + $signed(term);
					end
				end
			end
			prod = {64'd0, acc} * {64'd0, INV_PI_Q64};
			hq = prod[127:64];
		end
		return (hq + (64'd1 << (62 - ANGLE_BITS))) >> (63 - ANGLE_BITS);
	endfunction

	// 1/K in Q62
	function automatic logic [63:0] inv_gain();
		logic [63:0]  q;
		logic [63:0]  r;
		logic [63:0]  c;
		logic [127:0] n;
		q = 64'd1 << 62;
		for (int i = 0; i < CORDIC_STAGES; i++) begin
			if (2 * i <= 60) begin
				q = q - udiv64(q, (64'd1 << (2 * i)) + 64'd1);
			end
		end
		n = {64'd0, q} << 62;
		r = '0;
		for (int b = 61; b >= 0; b--) begin
			c = r | (64'd1 << b);
			if ({64'd0, c} * {64'd0, c} <= n) begin
				r = c;
			end
		end
		return r;
	endfunction

	localparam logic [63:0] INV_GAIN = inv_gain();

endpackage

>>> hdl/cartesian_to_spherical.sv
// ----------------------------------------------------------------------------
// cartesian_to_spherical
// Converts a signed 3D point to length, azimuth and zenith angle/latitude.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready carries coord_x/y/z; output channel
// out_valid/out_ready carries vector_length, azimuth and polar_angle.
// Angles are half-turn fractions, 2^31 = 180 degrees.
// angle_mode_we/angle_mode_wdata write the mode bit (0 zenith, 1 latitude);
// write it only while the block is empty.
// The pipeline holds one set-up stage, two 28-stage CORDIC chains,
// two 2-stage multipliers for the 1/K gain, one rounding stage and the
// output register. Throughput is one request per cycle while en is high.
// The whole pipeline advances on one enable: it moves whenever the output
// register is empty or being taken. When the receiver holds out_ready low
// with a result waiting, every stage holds and in_ready drops; nothing is
// lost or repeated.
// Reset clears all valid bits and sets angle_mode to zenith.
// ----------------------------------------------------------------------------
module cartesian_to_spherical (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [23:0] coord_x,
	input  logic [23:0] coord_y,
	input  logic [23:0] coord_z,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [23:0] vector_length,
	output logic [31:0] azimuth,
	output logic [31:0] polar_angle,
	input  logic        angle_mode_we,
	input  logic        angle_mode_wdata
);

	localparam int WB = c2s_pkg::WORK_BITS;
	localparam int AB = c2s_pkg::ACC_BITS;
	localparam int LB = c2s_pkg::LEN_BITS;
	localparam int OB = c2s_pkg::OUT_ANG_BITS;
	localparam int RS = 62;
	localparam int LS = 62 + c2s_pkg::WORK_SHIFT;

	logic en;
	logic mode_q;

	// set-up stage
	logic           v_s1;
	c2s_pkg::work_t x_s1, y_s1;
	c2s_pkg::acc_t  a_s1;
	c2s_pkg::side_t sd_s1;

	c2s_pkg::work_t sx, sy, sz;
	c2s_pkg::work_t px, py;
	c2s_pkg::acc_t  pa;
	c2s_pkg::side_t pside;

	// chain / multiplier links
	logic           c1_v, m1_v, c2_v, m2_v;
	c2s_pkg::work_t c1_x, c2_x;
	c2s_pkg::acc_t  c1_a, c2_a;
	c2s_pkg::side_t c1_sd, c1_sd_m, m1_sd, c2_sd, c2_sd_m, m2_sd, c2_in_sd;
	logic [127:0]   m1_p, m2_p;

	// rounding stage
	logic           v_s2;
	c2s_pkg::work_t rxy_s2;
	c2s_pkg::side_t sd_s2;
	logic [WB-1:0]  rxy_r;

	// output stage
	logic           v_q;
	logic [LB-1:0]  len_q;
	logic [OB-1:0]  az_q, pol_q;
	logic [127-LS+1:0] len_r;
	c2s_pkg::acc_t  lat_c;
	logic signed [AB:0] zen;
	logic [OB-1:0]  pol_n;

	assign en       = out_ready | ~v_q;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (angle_mode_we) begin
			mode_q <= angle_mode_wdata;
		end
	end

	// scale into the work format and fold the left half plane
	always_comb begin
		sx = WB'($signed(coord_x)) <<< c2s_pkg::WORK_SHIFT;
		sy = WB'($signed(coord_y)) <<< c2s_pkg::WORK_SHIFT;
		sz = WB'($signed(coord_z)) <<< c2s_pkg::WORK_SHIFT;
		px = sx;
		py = sy;
		pa = '0;
		if (sx[WB-1]) begin
			if (!sy[WB-1]) begin
				px = sy;
				py = -sx;
				pa = c2s_pkg::QUARTER;
			end else begin
				px = -sy;
				py = sx;
				pa = -c2s_pkg::QUARTER;
			end
		end
		pside.z    = sz;
		pside.az   = '0;
		pside.lat  = '0;
		pside.skip = (coord_x == '0) && (coord_y == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1  <= px;
			y_s1  <= py;
			a_s1  <= pa;
			sd_s1 <= pside;
		end
	end

	c2s_cordic_chain u_chain_xy (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s1),
		.in_x     (x_s1),
		.in_y     (y_s1),
		.in_ang   (a_s1),
		.in_side  (sd_s1),
		.out_valid(c1_v),
		.out_x    (c1_x),
		.out_ang  (c1_a),
		.out_side (c1_sd)
	);

	always_comb begin
		c1_sd_m    = c1_sd;
		c1_sd_m.az = c1_sd.skip ? '0 : c1_a;
	end

	c2s_mul u_mul_xy (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (c1_v),
		.a        (c1_sd.skip ? '0 : c1_x),
		.b        (c2s_pkg::INV_GAIN),
		.in_side  (c1_sd_m),
		.out_valid(m1_v),
		.prod     (m1_p),
		.out_side (m1_sd)
	);

	// round half up: floor(p / 2^62) plus the bit below
	assign rxy_r = m1_p[RS+WB-1:RS] + WB'(m1_p[RS-1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= m1_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rxy_s2 <= $signed(rxy_r);
			sd_s2  <= m1_sd;
		end
	end

	always_comb begin
		c2_in_sd      = sd_s2;
		c2_in_sd.skip = (rxy_s2 == '0) && (sd_s2.z == '0);
	end

	c2s_cordic_chain u_chain_rz (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s2),
		.in_x     (rxy_s2),
		.in_y     (sd_s2.z),
		.in_ang   ('0),
		.in_side  (c2_in_sd),
		.out_valid(c2_v),
		.out_x    (c2_x),
		.out_ang  (c2_a),
		.out_side (c2_sd)
	);

	always_comb begin
		c2_sd_m     = c2_sd;
		c2_sd_m.lat = c2_sd.skip ? '0 : c2_a;
	end

	c2s_mul u_mul_len (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (c2_v),
		.a        (c2_sd.skip ? '0 : c2_x),
		.b        (c2s_pkg::INV_GAIN),
		.in_side  (c2_sd_m),
		.out_valid(m2_v),
		.prod     (m2_p),
		.out_side (m2_sd)
	);

	// length, latitude clamp and zenith angle
	always_comb begin
		len_r = (128 - LS + 1)'(m2_p[127:LS]) + (128 - LS + 1)'(m2_p[LS-1]);
		lat_c = m2_sd.lat;
		if (m2_sd.lat > c2s_pkg::QUARTER) begin
			lat_c = c2s_pkg::QUARTER;
		end else if (m2_sd.lat < -c2s_pkg::QUARTER) begin
			lat_c = -c2s_pkg::QUARTER;
		end
		zen = (AB + 1)'(c2s_pkg::QUARTER) - (AB + 1)'(lat_c);
		if (zen > c2s_pkg::HALF_M1) begin
			zen = c2s_pkg::HALF_M1;
		end
		if (mode_q) begin
			pol_n = OB'(lat_c);
		end else if (m2_sd.skip) begin
			pol_n = '0;
		end else begin
			pol_n = OB'(zen);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= m2_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			len_q <= (len_r > (128 - LS + 1)'({LB{1'b1}})) ? {LB{1'b1}} : LB'(len_r);
			az_q  <= OB'(m2_sd.az);
			pol_q <= pol_n;
		end
	end

	assign out_valid     = v_q;
	assign vector_length = len_q;
	assign azimuth       = az_q;
	assign polar_angle   = pol_q;

endmodule

>>> hdl/c2s_cordic_chain.sv
// ----------------------------------------------------------------------------
// c2s_cordic_chain
// Pipelined CORDIC vectoring chain, one micro-rotation per register stage.
// ----------------------------------------------------------------------------
module c2s_cordic_chain (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  c2s_pkg::work_t     in_x,
	input  c2s_pkg::work_t     in_y,
	input  c2s_pkg::acc_t      in_ang,
	input  c2s_pkg::side_t     in_side,
	output logic               out_valid,
	output c2s_pkg::work_t     out_x,
	output c2s_pkg::acc_t      out_ang,
	output c2s_pkg::side_t     out_side
);

	localparam int N  = c2s_pkg::CORDIC_STAGES;
	localparam int AB = c2s_pkg::ACC_BITS;

	logic           v_s   [0:N];
	c2s_pkg::work_t x_s   [0:N];
	c2s_pkg::work_t y_s   [0:N];
	c2s_pkg::acc_t  a_s   [0:N];
	c2s_pkg::side_t sd_s  [0:N];

	assign v_s[0]  = in_valid;
	assign x_s[0]  = in_x;
	assign y_s[0]  = in_y;
	assign a_s[0]  = in_ang;
	assign sd_s[0] = in_side;

	for (genvar i = 0; i < N; i++) begin : g_stage
		localparam c2s_pkg::acc_t TAB = AB'(c2s_pkg::atan_entry(i));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		// both shifts use the old x and y
		always_ff @(posedge clk) begin
			if (en) begin
				if (!y_s[i][c2s_pkg::WORK_BITS-1]) begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					a_s[i+1] <= a_s[i] + TAB;
				end else begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					a_s[i+1] <= a_s[i] - TAB;
				end
				sd_s[i+1] <= sd_s[i];
			end
		end
	end

	assign out_valid = v_s[N];
	assign out_x     = x_s[N];
	assign out_ang   = a_s[N];
	assign out_side  = sd_s[N];

endmodule

>>> hdl/c2s_mul.sv
// ----------------------------------------------------------------------------
// c2s_mul
// 64 x 64 unsigned multiply in two stages: 32-bit partial products, then sum.
// ----------------------------------------------------------------------------
module c2s_mul (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  logic [63:0]    a,
	input  logic [63:0]    b,
	input  c2s_pkg::side_t in_side,
	output logic           out_valid,
	output logic [127:0]   prod,
	output c2s_pkg::side_t out_side
);

	logic           v_s1, v_s2;
	logic [63:0]    p00_s1, p01_s1, p10_s1, p11_s1;
	c2s_pkg::side_t sd_s1, sd_s2;
	logic [127:0]   prod_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p00_s1  <= a[31:0]  * b[31:0];
			p01_s1  <= a[31:0]  * b[63:32];
			p10_s1  <= a[63:32] * b[31:0];
			p11_s1  <= a[63:32] * b[63:32];
			sd_s1   <= in_side;
			prod_s2 <= {64'd0, p00_s1} + ({64'd0, p01_s1} << 32)
			         + ({64'd0, p10_s1} << 32) + {p11_s1, 64'd0};
			sd_s2   <= sd_s1;
		end
	end

	assign out_valid = v_s2;
	assign prod      = prod_s2;
	assign out_side  = sd_s2;

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Cartesian to spherical converter. A directed
// table covers zero and axis vectors, coordinate extremes, the azimuth wrap
// and the zenith saturation in both angle modes. Random points follow, in
// phases that alternate the mode. Both handshakes idle at random. Every
// result is checked in order against an integer CORDIC predictor.
// ----------------------------------------------------------------------------
module tb_top;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int     LATENCY_WAIT = 80;
	localparam int     IDLE_LIMIT   = 2000;
	localparam longint QTR          = 64'sd1 << 30;
	localparam longint HALF_TURN    = 64'sd1 << 31;

	typedef logic signed [c2s_pkg::COORD_BITS-1:0] coord_t;

	typedef struct {
		logic [c2s_pkg::LEN_BITS-1:0]     len;
		logic [c2s_pkg::OUT_ANG_BITS-1:0] az;
		logic [c2s_pkg::OUT_ANG_BITS-1:0] polar;
	} sph_t;

	typedef struct {
		coord_t x;
		coord_t y;
		coord_t z;
		logic   mode;
		logic   typed;
		sph_t   res;
	} row_t;

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	logic [23:0] coord_x, coord_y, coord_z, vector_length;
	logic [31:0] azimuth, polar_angle;
	logic angle_mode_we, angle_mode_wdata;

	cartesian_to_spherical uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
		.out_valid(out_valid), .out_ready(out_ready),
		.vector_length(vector_length), .azimuth(azimuth), .polar_angle(polar_angle),
		.angle_mode_we(angle_mode_we), .angle_mode_wdata(angle_mode_wdata)
	);

	longint      atan_lut[c2s_pkg::CORDIC_STAGES];
	logic [63:0] gain_comp;
	logic        cur_mode;
	sph_t        pending[$];
	int          errors;
	int          idle_cycles;
	bit          in_burst, out_burst;
	bit          rx_running;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// atan(2^-i)/pi as half-turn codes, and 1/K in Q62
	function automatic void build_luts();
		longint      acc, term, hq;
		logic [127:0] prod;
		logic [63:0] q, r, c;
		int          e;
		q = 64'd1 << 62;
		for (int i = 0; i < c2s_pkg::CORDIC_STAGES; i++) begin
			if (i == 0) begin
				hq = 64'sd1 << 60;
			end else begin
				acc = 0;
				for (int k = 0; k < 64; k++) begin
					e = 62 - i * (2 * k + 1);
					if (e >= 0) begin
						term = (64'sd1 << e) / longint'(2 * k + 1);
						acc = (k % 2 == 1) ? acc - term : acc + term;
					end
				end
				prod = {64'd0, acc} * {64'd0, c2s_pkg::INV_PI_Q64};
				hq = prod[127:64];
			end
			atan_lut[i] = (hq + (64'sd1 << 30)) >>> 31;
			if (2 * i <= 60)
				q = q - q / ((64'd1 << (2 * i)) + 64'd1);
		end
		r = '0;
		for (int b = 61; b >= 0; b--) begin
			c = r | (64'd1 << b);
			if ({64'd0, c} * {64'd0, c} <= ({64'd0, q} << 62))
				r = c;
		end
		gain_comp = r;
	endfunction

	function automatic longint gain_round(longint v, int s);
		logic [127:0] p;
		p = {64'd0, v} * {64'd0, gain_comp};
		p = p + (128'd1 << (s - 1));
		p = p >> s;
		return longint'(p[63:0]);
	endfunction

	// rotate (x, y) onto the +x axis; returns the final x, accumulates the angle
	function automatic longint rotate_to_axis(longint x, longint y, inout longint ang);
		longint dx, dy;
		for (int i = 0; i < c2s_pkg::CORDIC_STAGES; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x = x + dx; y = y - dy; ang = ang + atan_lut[i];
			end else begin
				x = x - dx; y = y + dy; ang = ang - atan_lut[i];
			end
		end
		return x;
	endfunction

	function automatic sph_t to_spherical(coord_t cx, coord_t cy, coord_t cz, logic mode);
		longint x, y, z, t, az, lat, rxy1, rxy, lw, polar;
		logic [63:0] len;
		sph_t r;
		x = longint'(cx) <<< c2s_pkg::WORK_SHIFT;
		y = longint'(cy) <<< c2s_pkg::WORK_SHIFT;
		z = longint'(cz) <<< c2s_pkg::WORK_SHIFT;
		az = 0; lat = 0; rxy1 = 0; rxy = 0; lw = 0; len = 0;
		if (x != 0 || y != 0) begin
			// left half plane: pre-rotate by a quarter turn
			if (x < 0) begin
				t = x;
				if (y >= 0) begin
					x = y; y = -t; az = QTR;
				end else begin
					x = -y; y = t; az = -QTR;
				end
			end
			rxy1 = rotate_to_axis(x, y, az);
		end
		if (rxy1 > 0)
			rxy = gain_round(rxy1, 62);
		if (rxy != 0 || z != 0)
			lw = rotate_to_axis(rxy, z, lat);
		if (lw > 0)
			len = gain_round(lw, 62 + c2s_pkg::WORK_SHIFT);
		if (len > 64'hFFFFFF)
			len = 64'hFFFFFF;
		if (lat > QTR)
			lat = QTR;
		if (lat < -QTR)
			lat = -QTR;
		if (mode)
			polar = lat;
		else if (rxy == 0 && z == 0)
			polar = 0;
		else begin
			polar = QTR - lat;
			if (polar > HALF_TURN - 1)
				polar = HALF_TURN - 1;
		end
		r.len = len[23:0];
		r.az = az[31:0];
		r.polar = polar[31:0];
		return r;
	endfunction

	function automatic coord_t pick_coord();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 2) begin
			case ($urandom_range(0, 4))
				0: return 24'sh7FFFFF;
				1: return 24'sh800000;
				2: return '0;
				3: return -24'sd1;
				default: return 24'sd1;
			endcase
		end
		if (sel < 5)
			return coord_t'($signed($urandom_range(0, 510)) - 255);
		return coord_t'($urandom);
	endfunction

	function automatic int draw_gap(bit burst);
		return burst ? 0 : $urandom_range(0, 12);
	endfunction

	// one request: optional gap, then hold valid until taken
	task automatic send(coord_t x, coord_t y, coord_t z, bit typed, sph_t res);
		int gap;
		bit taken;
		gap = draw_gap(in_burst);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		coord_x <= x;
		coord_y <= y;
		coord_z <= z;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = in_ready;
			@(posedge clk);
		end
		pending.push_back(typed ? res : to_spherical(x, y, z, cur_mode));
	endtask

	task automatic set_mode(logic m);
		in_valid <= 1'b0;
		wait (pending.size() == 0);
		repeat (LATENCY_WAIT) @(posedge clk);
		angle_mode_we <= 1'b1;
		angle_mode_wdata <= m;
		@(posedge clk);
		angle_mode_we <= 1'b0;
		cur_mode = m;
	endtask

	// receiver
	initial begin
		int stall;
		bit taken;
		sph_t want;
		out_ready = 1'b0;
		wait (rx_running);
		forever begin
			stall = draw_gap(out_burst);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			taken = 1'b0;
			while (!taken) begin
				@(negedge clk);
				taken = out_valid;
				if (taken) begin
					if (pending.size() == 0) begin
						$display("%0t: result with nothing expected: len %0d az %h polar %h",
							$time, vector_length, azimuth, polar_angle);
						errors++;
					end else begin
						want = pending.pop_front();
						if (vector_length !== want.len) begin
							$display("%0t: vector_length expected %0d got %0d",
								$time, want.len, vector_length);
							errors++;
						end
						if (azimuth !== want.az) begin
							$display("%0t: azimuth expected %h got %h", $time, want.az, azimuth);
							errors++;
						end
						if (polar_angle !== want.polar) begin
							$display("%0t: polar_angle expected %h got %h",
								$time, want.polar, polar_angle);
							errors++;
						end
					end
				end
				@(posedge clk);
			end
			if ($urandom_range(0, 40) == 0)
				out_burst = ~out_burst;
		end
	end

	always @(negedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		row_t  rows[$];
		sph_t  zero_res;
		coord_t mx, mn;
		arst_n = 1'b0;
		in_valid = 1'b0;
		coord_x = '0;
		coord_y = '0;
		coord_z = '0;
		angle_mode_we = 1'b0;
		angle_mode_wdata = 1'b0;
		errors = 0;
		idle_cycles = 0;
		in_burst = 1'b0;
		out_burst = 1'b0;
		rx_running = 1'b0;
		cur_mode = 1'b0;
		build_luts();
		zero_res = '{len: '0, az: '0, polar: '0};
		mx = 24'sh7FFFFF;
		mn = 24'sh800000;

		rows = '{
			'{x: 0,  y: 0,  z: 0,  mode: 0, typed: 1, res: zero_res},
			'{x: mx, y: 0,  z: 0,  mode: 0, typed: 0, res: zero_res},
			'{x: mn, y: 0,  z: 0,  mode: 0, typed: 0, res: zero_res},
			'{x: -5, y: 0,  z: 0,  mode: 0, typed: 0, res: zero_res},
			'{x: 0,  y: mx, z: 0,  mode: 0, typed: 0, res: zero_res},
			'{x: 0,  y: mn, z: 0,  mode: 0, typed: 0, res: zero_res},
			'{x: 0,  y: 0,  z: mx, mode: 0, typed: 0, res: zero_res},
			'{x: 0,  y: 0,  z: mn, mode: 0, typed: 0, res: zero_res},
			'{x: 0,  y: 0,  z: -1, mode: 0, typed: 0, res: zero_res},
			'{x: mx, y: mx, z: mx, mode: 0, typed: 0, res: zero_res},
			'{x: mn, y: mn, z: mn, mode: 0, typed: 0, res: zero_res},
			'{x: -1, y: 1,  z: 0,  mode: 0, typed: 0, res: zero_res},
			'{x: -1, y: -1, z: 1,  mode: 0, typed: 0, res: zero_res},
			'{x: mx, y: mn, z: mx, mode: 0, typed: 0, res: zero_res},
			'{x: 0,  y: 0,  z: 0,  mode: 1, typed: 1, res: zero_res},
			'{x: 0,  y: 0,  z: mx, mode: 1, typed: 0, res: zero_res},
			'{x: 0,  y: 0,  z: mn, mode: 1, typed: 0, res: zero_res},
			'{x: mn, y: 0,  z: 0,  mode: 1, typed: 0, res: zero_res},
			'{x: 1,  y: 1,  z: 1,  mode: 1, typed: 0, res: zero_res},
			'{x: mn, y: mn, z: mn, mode: 1, typed: 0, res: zero_res},
			'{x: mx, y: mx, z: mx, mode: 1, typed: 0, res: zero_res},
			'{x: -7, y: 3,  z: -9, mode: 1, typed: 0, res: zero_res}
		};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		rx_running = 1'b1;

		foreach (rows[i]) begin
			if (rows[i].mode != cur_mode)
				set_mode(rows[i].mode);
			send(rows[i].x, rows[i].y, rows[i].z, rows[i].typed, rows[i].res);
		end

		for (int ph = 0; ph < 4; ph++) begin
			set_mode(ph % 2 == 1);
			for (int n = 0; n < 150; n++) begin
				send(pick_coord(), pick_coord(), pick_coord(), 1'b0, zero_res);
				if ($urandom_range(0, 40) == 0)
					in_burst = ~in_burst;
			end
		end
		in_valid <= 1'b0;

		wait (pending.size() == 0);
		repeat (LATENCY_WAIT) @(posedge clk);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
